FILE: rtl/core/fba_pkg.sv
// fba_pkg: shared types, codes and helper functions of the frame bitmap allocator
// no dependencies; used by frame_bitmap_allocator_top and the testbench

package fba_pkg;

    // sizing
    localparam int NUM_FRAMES_DEF = 16384;
    localparam int PAGE_SHIFT     = 12;     // 4 KiB pages
    localparam int WORD_BITS      = 32;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [19:0] entry_frame;
        logic [31:0] address;
        logic        supervisor;
        logic        writable;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] frame_number;
        logic [31:0] page_entry;
        logic        frame_used;
    } t_rsp;

    // ones in every bit position at or above valid
    function automatic logic [WORD_BITS-1:0] pad_mask(input int valid);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (i >= valid);
        end
        return m;
    endfunction

    // index of the lowest zero bit, 0 when the word is all ones
    function automatic logic [4:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/fba_ram.sv
// fba_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/frame_bitmap_allocator_top.sv
// frame_bitmap_allocator_top: first-fit page frame allocator over a usage bitmap ram
// depends on fba_pkg and fba_ram (bitmap ram and full-word hint ram)
//
//  channel   | ports                | handshake
//  ----------+----------------------+------------------------------------------
//  request   | start, busy, i_req   | taken at an edge with start high, busy low
//  result    | o_strobe, o_rsp      | one cycle per result, cannot be held off
//
// free and test of an in-range frame read the ram, then write back or compare;
// allocate scans the hint ram word by word, each entry covering 32 bitmap words,
// past the full ones, then reads one bitmap word and takes its lowest free frame;
// a refusal on a full map follows a scan of every hint word; others answer from idle.
// the result strobe is registered and comes in the cycle after the request's last state.
// after reset a clearing pass writes every bitmap word, one per cycle
// ((NUM_FRAMES+31)/32 words, 512 by default), with busy high.
// the result side has no stall; busy is the only back-pressure.

module frame_bitmap_allocator_top #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fba_pkg::t_req i_req,
    output logic          o_strobe,
    output fba_pkg::t_rsp o_rsp
);

    // bitmap words and hint words (one hint bit per bitmap word, 1 = word full)
    localparam int WORDS  = (NUM_FRAMES + 31) / 32;
    localparam int HWORDS = (WORDS + 31) / 32;
    localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int HAW    = (HWORDS > 1) ? $clog2(HWORDS) : 1;
    // frames past NUM_FRAMES and words past WORDS start out marked used/full
    localparam logic [31:0] BPAD = fba_pkg::pad_mask(NUM_FRAMES - (WORDS - 1) * 32);
    localparam logic [31:0] HPAD = fba_pkg::pad_mask(WORDS - (HWORDS - 1) * 32);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HCHK,     // hint word read back, look for a non-full bitmap word
        S_BCHK,     // bitmap word read back, take lowest free frame
        S_FWR,      // free: write back cleared bit and hint
        S_TRD       // test: bitmap word read back
    } t_state;

    t_state        r_state, n_state;
    logic [WAW-1:0] r_clr, n_clr;
    logic [HAW-1:0] r_hptr, n_hptr;     // every hint word below this one is full
    logic [WAW-1:0] r_word, n_word;
    logic [4:0]     r_hbit, n_hbit;
    logic [31:0]    r_hdata, n_hdata;
    logic [19:0]    r_frame, n_frame;
    fba_pkg::t_req  r_req, n_req;
    logic           r_strobe, n_strobe;
    fba_pkg::t_rsp  r_rsp, n_rsp;

    // ram ports
    logic           bm_we, bm_re, hm_we, hm_re;
    logic [WAW-1:0] bm_waddr, bm_raddr;
    logic [HAW-1:0] hm_waddr, hm_raddr;
    logic [31:0]    bm_wdata, bm_rdata, hm_wdata, hm_rdata;

    fba_ram #(.WIDTH(32), .DEPTH(WORDS), .AW(WAW)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (bm_we),
        .i_waddr(bm_waddr),
        .i_wdata(bm_wdata),
        .i_re   (bm_re),
        .i_raddr(bm_raddr),
        .o_rdata(bm_rdata)
    );

    fba_ram #(.WIDTH(32), .DEPTH(HWORDS), .AW(HAW)) u_hint (
        .i_clk  (i_clk),
        .i_we   (hm_we),
        .i_waddr(hm_waddr),
        .i_wdata(hm_wdata),
        .i_re   (hm_re),
        .i_raddr(hm_raddr),
        .o_rdata(hm_rdata)
    );

    // frame decode: incoming request while idle, stored frame afterwards
    logic [19:0]    in_frame, cur_frame, cur_wsh, cur_hsh;
    logic           in_range;
    logic [WAW-1:0] cur_word;
    logic [HAW-1:0] cur_hidx;
    logic [4:0]     cur_bit, cur_hbit;

    assign in_frame  = (i_req.operation == fba_pkg::OP_TEST)
                     ? 20'(i_req.address >> fba_pkg::PAGE_SHIFT) : i_req.entry_frame;
    assign in_range  = ({1'b0, in_frame} < 21'(NUM_FRAMES));
    assign cur_frame = (r_state == S_IDLE) ? in_frame : r_frame;
    assign cur_wsh   = cur_frame >> 5;
    assign cur_hsh   = cur_frame >> 10;
    assign cur_word  = cur_wsh[WAW-1:0];
    assign cur_hidx  = cur_hsh[HAW-1:0];
    assign cur_bit   = cur_frame[4:0];
    assign cur_hbit  = cur_wsh[4:0];

    // allocation helpers
    logic [4:0]     hint_zero, bm_zero;
    logic [HAW+4:0] hint_word_wide;
    logic [WAW+4:0] pick_frame_wide;
    logic [19:0]    pick_frame;
    logic [31:0]    bm_set;

    assign hint_zero       = fba_pkg::lowest_zero(hm_rdata);
    assign hint_word_wide  = {r_hptr, hint_zero};
    assign bm_zero         = fba_pkg::lowest_zero(bm_rdata);
    assign bm_set          = bm_rdata | (32'd1 << bm_zero);
    assign pick_frame_wide = {r_word, bm_zero};
    assign pick_frame      = 20'(pick_frame_wide);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_hptr   = r_hptr;
        n_word   = r_word;
        n_hbit   = r_hbit;
        n_hdata  = r_hdata;
        n_frame  = r_frame;
        n_req    = r_req;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        bm_we    = 1'b0;
        bm_waddr = cur_word;
        bm_wdata = '0;
        bm_re    = 1'b0;
        bm_raddr = cur_word;
        hm_we    = 1'b0;
        hm_waddr = cur_hidx;
        hm_wdata = '0;
        hm_re    = 1'b0;
        hm_raddr = cur_hidx;

        unique case (r_state)
            S_CLEAR: begin
                // one bitmap word per cycle, hint words along with the first few
                bm_we    = 1'b1;
                bm_waddr = r_clr;
                bm_wdata = (r_clr == WAW'(WORDS - 1)) ? BPAD : '0;
                if ({1'b0, r_clr} < (WAW + 1)'(HWORDS)) begin
                    hm_we    = 1'b1;
                    hm_waddr = r_clr[HAW-1:0];
                    hm_wdata = (r_clr == WAW'(HWORDS - 1)) ? HPAD : '0;
                end
                if (r_clr == WAW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_frame = in_frame;
                    unique case (i_req.operation)
                        fba_pkg::OP_ALLOC: begin
                            hm_re    = 1'b1;
                            hm_raddr = r_hptr;
                            n_state  = S_HCHK;
                        end
                        fba_pkg::OP_FREE: begin
                            if (!in_range) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{fba_pkg::ST_RANGE, in_frame, 32'd0, 1'b0};
                            end else if (in_frame == '0) begin
                                // frame zero is never released
                                n_strobe = 1'b1;
                                n_rsp    = '{fba_pkg::ST_OK, 20'd0, 32'd0, 1'b0};
                            end else begin
                                bm_re   = 1'b1;
                                hm_re   = 1'b1;
                                n_state = S_FWR;
                            end
                        end
                        fba_pkg::OP_TEST: begin
                            if (!in_range) begin
                                n_strobe = 1'b1;
                                n_rsp    = '{fba_pkg::ST_RANGE, in_frame, 32'd0, 1'b0};
                            end else begin
                                bm_re   = 1'b1;
                                n_state = S_TRD;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_rsp    = '{fba_pkg::ST_OK, 20'd0, 32'd0, 1'b0};
                        end
                    endcase
                end
            end

            S_HCHK: begin
                if (&hm_rdata) begin
                    if (r_hptr == HAW'(HWORDS - 1)) begin
                        // every word full: nothing to hand out
                        n_strobe = 1'b1;
                        n_rsp    = '{fba_pkg::ST_NO_FREE, 20'd0, 32'd0, 1'b0};
                        n_state  = S_IDLE;
                    end else begin
                        n_hptr   = r_hptr + 1'b1;
                        hm_re    = 1'b1;
                        hm_raddr = r_hptr + 1'b1;
                    end
                end else begin
                    n_word   = hint_word_wide[WAW-1:0];
                    n_hbit   = hint_zero;
                    n_hdata  = hm_rdata;
                    bm_re    = 1'b1;
                    bm_raddr = hint_word_wide[WAW-1:0];
                    n_state  = S_BCHK;
                end
            end

            S_BCHK: begin
                bm_we    = 1'b1;
                bm_waddr = r_word;
                bm_wdata = bm_set;
                if (&bm_set) begin
                    // word just filled up: flag it in the hint
                    hm_we    = 1'b1;
                    hm_waddr = r_hptr;
                    hm_wdata = r_hdata | (32'd1 << r_hbit);
                end
                n_strobe = 1'b1;
                n_rsp    = '{fba_pkg::ST_OK, pick_frame,
                             {pick_frame, 9'd0, !r_req.supervisor, r_req.writable, 1'b1},
                             1'b0};
                n_state  = S_IDLE;
            end

            S_FWR: begin
                bm_we    = 1'b1;
                bm_wdata = bm_rdata & ~(32'd1 << cur_bit);
                hm_we    = 1'b1;
                hm_wdata = hm_rdata & ~(32'd1 << cur_hbit);
                // pull the scan start back to the freed word
                if (cur_hidx < r_hptr) begin
                    n_hptr = cur_hidx;
                end
                n_strobe = 1'b1;
                n_rsp    = '{fba_pkg::ST_OK, r_frame, 32'd0, 1'b0};
                n_state  = S_IDLE;
            end

            S_TRD: begin
                n_strobe = 1'b1;
                n_rsp    = '{fba_pkg::ST_OK, r_frame, 32'd0, bm_rdata[cur_bit]};
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_hptr   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_hptr   <= n_hptr;
            r_strobe <= n_strobe;
        end
        r_word  <= n_word;
        r_hbit  <= n_hbit;
        r_hdata <= n_hdata;
        r_frame <= n_frame;
        r_req   <= n_req;
        r_rsp   <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // a result always follows an accepted request or a cycle of work
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result strobe without a request");

    // rams are written only by the clearing pass or a request in flight
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!bm_we && !hm_we))
        else $error("ram write while idle");

    // no results come out during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_strobe)
        else $error("result during clearing pass");

    // the hint never points at a full bitmap word
    a_hint_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCHK) |-> !(&bm_rdata))
        else $error("hint selected a full bitmap word");

endmodule

FILE: test/tb.sv
// tb: self-checking testbench of frame_bitmap_allocator_top, first-fit frame allocation
// depends on fba_pkg and frame_bitmap_allocator_top; a ledger class predicts every result
`timescale 1ns / 1ps

// tracks which frames are taken and the results owed by the allocator
class alloc_ledger;
    localparam int FRAMES = fba_pkg::NUM_FRAMES_DEF;
    localparam int WORDS  = FRAMES / fba_pkg::WORD_BITS;

    bit [31:0]     map_words [WORDS];
    int            frames_in_use;
    fba_pkg::t_rsp expected_rsps [$];
    int            errors;
    int            n_requests, n_results, n_alloc, n_no_free, n_free, n_test, n_range, n_unused;

    function new();
        frames_in_use = 0;
        errors        = 0;
        n_requests    = 0;
        n_results     = 0;
        n_alloc       = 0;
        n_no_free     = 0;
        n_free        = 0;
        n_test        = 0;
        n_range       = 0;
        n_unused      = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // expected result of one request, updating the frame map on the way
    function fba_pkg::t_rsp predict_response(fba_pkg::t_req r);
        fba_pkg::t_rsp p;
        int            f;
        bit            found;
        p     = '0;
        f     = 0;
        found = 1'b0;
        case (r.operation)
            fba_pkg::OP_ALLOC: begin
                for (int w = 0; w < WORDS && !found; w++) begin
                    if (map_words[w] != '1) begin
                        for (int b = 0; b < 32 && !found; b++) begin
                            if (!map_words[w][b]) begin
                                found = 1'b1;
                                f     = w * 32 + b;
                            end
                        end
                    end
                end
                if (found) begin
                    map_words[f / 32][f % 32] = 1'b1;
                    frames_in_use++;
                    p.frame_number = 20'(f);
                    p.page_entry   = {20'(f), 9'd0, ~r.supervisor, r.writable, 1'b1};
                    n_alloc++;
                end else begin
                    p.status = fba_pkg::ST_NO_FREE;
                    n_no_free++;
                end
            end
            fba_pkg::OP_FREE: begin
                p.frame_number = r.entry_frame;
                n_free++;
                if (r.entry_frame >= FRAMES) begin
                    p.status = fba_pkg::ST_RANGE;
                    n_range++;
                end else if (r.entry_frame != 0) begin
                    f = r.entry_frame;
                    if (map_words[f / 32][f % 32]) begin
                        frames_in_use--;
                    end
                    map_words[f / 32][f % 32] = 1'b0;
                end
            end
            fba_pkg::OP_TEST: begin
                f              = r.address[31:12];
                p.frame_number = r.address[31:12];
                n_test++;
                if (f >= FRAMES) begin
                    p.status = fba_pkg::ST_RANGE;
                    n_range++;
                end else begin
                    p.frame_used = map_words[f / 32][f % 32];
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        return p;
    endfunction

    function void note_request(fba_pkg::t_req r);
        n_requests++;
        expected_rsps.push_back(predict_response(r));
    endfunction

    task check_result(fba_pkg::t_rsp got);
        fba_pkg::t_rsp want;
        n_results++;
        if (expected_rsps.size() == 0) begin
            report($sformatf("result %h with nothing outstanding", got));
            return;
        end
        want = expected_rsps.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %h, want %h", got.status, want.status));
        if (got.frame_number !== want.frame_number)
            report($sformatf("frame_number %h, want %h", got.frame_number, want.frame_number));
        if (got.page_entry !== want.page_entry)
            report($sformatf("page_entry %h, want %h", got.page_entry, want.page_entry));
        if (got.frame_used !== want.frame_used)
            report($sformatf("frame_used %b, want %b", got.frame_used, want.frame_used));
    endtask
endclass

module tb;

    localparam int         FRAMES        = fba_pkg::NUM_FRAMES_DEF;
    localparam logic [1:0] OP_UNUSED     = 2'd3;     // no operation behind this code
    localparam int         N_RANDOM      = 1225;
    localparam int         SETTLE_CYCLES = 40;       // well past the longest allocate
    // ~1250 requests with their work and the gaps between bursts,
    // plus the clearing pass after reset; several times over
    localparam int         CYCLE_LIMIT   = 200_000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    fba_pkg::t_req i_req;
    logic          o_strobe;
    fba_pkg::t_rsp o_rsp;

    alloc_ledger ledger;
    int          n_accepted  = 0;   // requests taken by the block so far
    int          cycles      = 0;
    int          burst_left  = 0;   // requests left in the current sender burst

    frame_bitmap_allocator_top #(
        .NUM_FRAMES (FRAMES)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // monitor: everything sampled at the rising edge, before the block updates
    // a result can never share an edge with its own request, so check first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                ledger.check_result(o_rsp);
            end
            if (start && busy === 1'b0) begin
                ledger.note_request(i_req);
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ledger.expected_rsps.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic fba_pkg::t_req mk(logic [1:0] op, logic [19:0] ef, logic [31:0] addr,
                                         logic k, logic w);
        fba_pkg::t_req r;
        r.operation   = op;
        r.entry_frame = ef;
        r.address     = addr;
        r.supervisor  = k;
        r.writable    = w;
        return r;
    endfunction

    // random request, biased toward frames near the part of the map in use
    function automatic fba_pkg::t_req random_req();
        fba_pkg::t_req r;
        int            pick;
        int            reach;
        r.entry_frame = 20'($urandom);
        r.address     = $urandom;
        r.supervisor  = 1'($urandom_range(0, 1));
        r.writable    = 1'($urandom_range(0, 1));
        reach         = ledger.frames_in_use + 48;
        pick          = $urandom_range(0, 99);
        if (pick < 40) begin
            r.operation = fba_pkg::OP_ALLOC;
        end else if (pick < 75) begin
            r.operation = fba_pkg::OP_FREE;
            pick        = $urandom_range(0, 9);
            if (pick < 7) begin
                r.entry_frame = 20'($urandom_range(0, reach));
            end else if (pick == 7) begin
                r.entry_frame = '0;
            end
            // otherwise keep the full 20-bit value, mostly out of range
        end else if (pick < 95) begin
            r.operation = fba_pkg::OP_TEST;
            if ($urandom_range(0, 3) != 0) begin
                r.address[31:12] = 20'($urandom_range(0, reach));
            end
        end else begin
            r.operation = OP_UNUSED;
        end
        return r;
    endfunction

    // hold start with the request until the block takes it; returns at a falling edge
    task automatic send(input fba_pkg::t_req r);
        int target;
        target = n_accepted + 1;
        start <= 1'b1;
        i_req <= r;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // send inside bursts of random length, random gaps between bursts
    task automatic issue(input fba_pkg::t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pause(gap);
            end
            burst_left = $urandom_range(1, 24);
        end
        send(r);
        burst_left--;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (ledger.expected_rsps.size() != 0);
    endtask

    initial begin
        ledger  = new();
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as busy, send simply waits

        // directed: empty map, allocate with every kernel / writeable mix
        issue(mk(fba_pkg::OP_TEST, 20'd0, 32'h0000_0000, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b0, 1'b1));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b1, 1'b0));
        issue(mk(fba_pkg::OP_ALLOC, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // test: low frame used, top of address space, last frame, first frame past the end
        issue(mk(fba_pkg::OP_TEST, 20'd0, 32'h0000_0FFF, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_TEST, 20'd0, 32'hFFFF_FFFF, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_TEST, 20'd0, {20'(FRAMES - 1), 12'hFFF}, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_TEST, 20'd0, {20'(FRAMES), 12'h000}, 1'b0, 1'b0));
        // freeing frame zero is ignored
        issue(mk(fba_pkg::OP_FREE, 20'd0, 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_TEST, 20'd0, 32'h0000_0000, 1'b0, 1'b0));
        // free a hole and take it back
        issue(mk(fba_pkg::OP_FREE, 20'd2, 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_TEST, 20'd0, 32'h0000_2000, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b1, 1'b1));
        // free: last frame (never used), first out of range, all ones
        issue(mk(fba_pkg::OP_FREE, 20'(FRAMES - 1), 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_FREE, 20'(FRAMES), 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_FREE, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // unused operation code, fields all ones then random
        issue(mk(OP_UNUSED, 20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        issue(mk(OP_UNUSED, 20'($urandom), $urandom, 1'b0, 1'b1));
        // two holes refilled lowest first
        issue(mk(fba_pkg::OP_FREE, 20'd3, 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_FREE, 20'd1, 32'd0, 1'b0, 1'b0));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b0, 1'b1));
        issue(mk(fba_pkg::OP_ALLOC, 20'd0, 32'd0, 1'b1, 1'b0));
        drain();

        // random mix, drained now and then so the block goes fully idle
        for (int i = 0; i < N_RANDOM; i++) begin
            issue(random_req());
            if (i % 300 == 299) begin
                drain();
            end
        end
        drain();

        // catch any stray strobe after the last result
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d allocations, %0d refused on a full map, %0d frees,",
                 ledger.n_requests, ledger.n_alloc, ledger.n_no_free, ledger.n_free);
        $display("  %0d tests, %0d out of range, %0d unused codes; %0d mismatches",
                 ledger.n_test, ledger.n_range, ledger.n_unused, ledger.errors);
        if (ledger.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
